// ----- hw/rtl/sha_pkg.sv -----
// Package for the SHA-256 hash engine: initial hash values, round constants
// and the round helper functions. No dependencies.
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int LengthLane = 56;
  localparam int NumRounds = 64;
  localparam int NumDigestWords = 8;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitHash [NumDigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ----- hw/rtl/sha_round_unit.sv -----
// One SHA-256 round: schedule word and working-variable update.
// Depends on sha_pkg.
module sha_round_unit (
  input  logic [31:0] work_in [8],
  input  logic [31:0] w2,
  input  logic [31:0] w7,
  input  logic [31:0] w15,
  input  logic [31:0] w16,
  input  logic        use_direct,
  input  logic [31:0] k_word,
  output logic [31:0] wr,
  output logic [31:0] work_out [8]
);
  import sha_pkg::*;

  logic [31:0] t1;
  logic [31:0] t2;

  // Schedule word: direct block word in the first 16 rounds.
  assign wr = use_direct ? w16 : (small_sigma1(w2) + w7 + small_sigma0(w15) + w16);

  assign t1 = work_in[7] + big_sigma1(work_in[4])
            + ((work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6])) + k_word + wr;
  assign t2 = big_sigma0(work_in[0])
            + ((work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2])
               ^ (work_in[1] & work_in[2]));

  // Shift the working variables down by one.
  always_comb begin
    work_out[0] = t1 + t2;
    work_out[1] = work_in[0];
    work_out[2] = work_in[1];
    work_out[3] = work_in[2];
    work_out[4] = work_in[3] + t1;
    work_out[5] = work_in[4];
    work_out[6] = work_in[5];
    work_out[7] = work_in[6];
  end

endmodule

// ----- hw/rtl/sha256_hash_engine_core.sv -----
// SHA-256 hash engine: byte stream in, eight digest words out.
// A byte that fills a block goes through accept, load, 64 rounds of the shared round
// unit, and add. A final item adds padding at one byte per cycle and one or two
// compressions, then 8 output words.
// Throughput: one item at a time. Reset: rst, synchronous, restores initial hash.
// Depends on sha_pkg and sha_round_unit.
module sha256_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // has_byte[0], is_final[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word[31:0]
  output logic [2:0]  m_tuser,   // word_index[2:0]
  output logic        m_tlast    // last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  state_t      state;
  logic [31:0] hash_words [8];
  logic [31:0] working_words [8];
  logic [31:0] schedule_window [16];
  logic [63:0] message_bit_count;
  logic [5:0]  block_byte_position;
  logic [5:0]  round;
  logic        finishing;
  logic        length_phase;
  logic [2:0]  out_index;
  // Marker pending: the 0x80 byte still has to open the padding.
  logic        marker_due;

  logic [31:0] wr;
  logic [31:0] work_next [8];
  logic [7:0]  pad_byte;
  logic [3:0]  rd;

  assign rd = round[3:0];

  sha_round_unit u_round (
    .work_in   (working_words),
    .w2        (schedule_window[4'(rd - 4'd2)]),
    .w7        (schedule_window[4'(rd - 4'd7)]),
    .w15       (schedule_window[4'(rd - 4'd15)]),
    .w16       (schedule_window[rd]),
    .use_direct(round < 6'd16),
    .k_word    (RoundK[round]),
    .wr        (wr),
    .work_out  (work_next)
  );

  // Padding byte after the 0x80 marker: zeros, then the length big-endian.
  always_comb begin
    if (!length_phase) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = message_bit_count[8*(7 - 32'(block_byte_position[2:0])) +: 8];
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = hash_words[out_index];
  assign m_tuser  = out_index;
  assign m_tlast  = (out_index == 3'd7);

  // Sequencer, byte packing and compression.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hash_words <= InitHash;
      message_bit_count <= '0;
      block_byte_position <= '0;
      finishing <= 1'b0;
      length_phase <= 1'b0;
      marker_due <= 1'b0;
      out_index <= '0;
      round <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0]) begin
              schedule_window[block_byte_position[5:2]]
                [8*(3 - 32'(block_byte_position[1:0])) +: 8] <= s_tdata;
              message_bit_count <= message_bit_count + 64'd8;
              block_byte_position <= block_byte_position + 6'd1;
            end
            finishing <= s_tuser[1];
            marker_due <= s_tuser[1];
            length_phase <= 1'b0;
            if (s_tuser[0] && block_byte_position == 6'd63) begin
              state <= ST_LOAD;
            end else if (s_tuser[1]) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // The first pad byte is the 0x80 marker.
          schedule_window[block_byte_position[5:2]]
            [8*(3 - 32'(block_byte_position[1:0])) +: 8] <=
            marker_due ? PadByte : pad_byte;
          marker_due <= 1'b0;
          block_byte_position <= block_byte_position + 6'd1;
          if (block_byte_position == 6'(LengthLane - 1)) length_phase <= 1'b1;
          if (block_byte_position == 6'd63) state <= ST_LOAD;
        end
        ST_LOAD: begin
          working_words <= hash_words;
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          working_words <= work_next;
          if (round >= 6'd16) schedule_window[rd] <= wr;
          round <= round + 6'd1;
          if (round == 6'(NumRounds - 1)) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < NumDigestWords; i++) begin
            hash_words[i] <= hash_words[i] + working_words[i];
          end
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (length_phase) begin
            out_index <= '0;
            state <= ST_OUT;
          end else begin
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) begin
              hash_words <= InitHash;
              message_bit_count <= '0;
              block_byte_position <= '0;
              finishing <= 1'b0;
              length_phase <= 1'b0;
              marker_due <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // Output is only presented after a full run of rounds.
  a_out_after_add: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_ADD) else $error("output without add");
  // No input is taken while digest words are pending.
  a_no_accept_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while outputting");
  // The word index holds while a word stalls.
  a_index_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_index)) else $error("index moved");
`endif

endmodule

// ----- tb/sv/sha256_digest_checker.sv -----
// Checker for the SHA-256 hash engine: watches both stream channels, hashes the
// accepted bytes itself and compares every digest word. Depends on sha_pkg.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // has_byte[0], is_final[1]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // digest_word[31:0]
  input  logic [2:0]  m_tuser,   // word_index[2:0]
  input  logic        m_tlast,   // last_word
  output int          fail_count,
  output int          pending_words
);
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  digest_word_t digest_queue[$];

  logic [31:0] chain[NumDigestWords];
  logic [31:0] block_words[16];
  logic [63:0] bit_count;
  logic [5:0]  lane;

  function automatic logic [31:0] ror32(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Runs the 64 rounds over the current block and folds the result into chain.
  task automatic compress();
    logic [31:0] v[8];
    logic [31:0] w[16];
    logic [31:0] wr, t1, t2, w2, w15;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int r = 0; r < NumRounds; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        w2 = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        wr = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + w[(r - 7) & 15]
           + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wr;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb(logic [7:0] b);
    int sh;
    sh = (3 - lane[1:0]) * 8;
    block_words[lane[5:2]][sh +: 8] = b;
    lane = lane + 6'd1;
    if (lane == 0) compress();
  endtask

  task automatic hash_item(logic [7:0] b, logic has, logic fin);
    logic [63:0] len;
    digest_word_t d;
    if (has) begin
      bit_count = bit_count + 64'd8;
      absorb(b);
    end
    if (fin) begin
      len = bit_count;
      absorb(PadByte);
      while (lane != LengthLane) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(len[i*8 +: 8]);
      for (int i = 0; i < NumDigestWords; i++) begin
        d.digest_word = chain[i];
        d.word_index = i[2:0];
        d.last_word = (i == NumDigestWords - 1);
        digest_queue.insert(digest_queue.size(), d);
      end
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      bit_count = '0;
      lane = '0;
    end
  endtask

  // Predict on accepted input words, compare on accepted output words.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      bit_count = '0;
      lane = '0;
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) hash_item(s_tdata, s_tuser[0], s_tuser[1]);
      if (m_tvalid && m_tready) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word %h idx %0d last %b", m_tdata, m_tuser, m_tlast);
        end else begin
          exp_w = digest_queue.pop_front();
          if (exp_w.digest_word !== m_tdata || exp_w.word_index !== m_tuser ||
              exp_w.last_word !== m_tlast) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
    pending_words = digest_queue.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the SHA-256 hash engine testbench: clock, reset, byte stimulus,
// output stalls and verdict. Depends on sha256_hash_engine_core and the checker.
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte[7:0]
  logic [1:0]  s_tuser = '0;   // has_byte[0], is_final[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // digest_word[31:0]
  logic [2:0]  m_tuser;        // word_index[2:0]
  logic        m_tlast;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  int          rx_wait = 0;
  bit          hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256_hash_engine_core u_dut (.*);

  sha256_digest_checker u_chk (.*);

  // Hands one byte word to the engine after a random gap.
  task automatic send_word(logic [7:0] b, logic has, logic fin);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= {fin, has};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sends a message of n random bytes; the last byte may ride on the final word.
  task automatic send_message(int n, bit ride = 1'b0);
    bit on_final;
    on_final = (n > 0) && (ride || $urandom_range(0, 1));
    for (int i = 0; i < n - on_final; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'h00, 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), on_final, 1'b1);
  endtask

  // Receiver: randomly drops ready after accepted words, and holds off on request.
  always @(posedge clk) begin
    int w;
    if (rst || hold_off) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin
        w = $urandom_range(0, 13);
        m_tready <= (w == 0);
        rx_wait <= w;
      end
    end else if (rx_wait <= 1) begin
      m_tready <= 1'b1;
      rx_wait <= 0;
    end else begin
      rx_wait <= rx_wait - 1;
    end
  end

  // One long hold-off of the receiver while bytes keep coming.
  initial begin
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int sent;
    int lens[3];
    lens = '{55, 56, 64};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty message, extreme bytes, padding boundaries, idle words.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_message(3);
    send_message(1);
    sent = 12;
    // A full block whose last byte rides on the final word opens a fresh pad block.
    foreach (lens[k]) begin
      send_message(lens[k], lens[k] == 64);
      sent += lens[k] + 1;
    end
    // Random messages, mostly short.
    while (sent < 270) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 100) : $urandom_range(0, 20);
      send_message(n);
      sent += n + 1;
    end
    s_tvalid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
